/* src/ppseq_pkg.sv */
// Package with opcodes, state encoding and helpers for the payload power sequencer.
`default_nettype none

package ppseq_pkg;

    localparam int OP_W   = 4;
    localparam int CODE_W = 3;

    // Input item opcodes.
    localparam logic [OP_W-1:0] OP_TICK      = 4'd0;
    localparam logic [OP_W-1:0] OP_P12_GOOD  = 4'd1;
    localparam logic [OP_W-1:0] OP_P12_LOST  = 4'd2;
    localparam logic [OP_W-1:0] OP_CORE_GOOD = 4'd3;
    localparam logic [OP_W-1:0] OP_CORE_LOST = 4'd4;
    localparam logic [OP_W-1:0] OP_QUIESCE   = 4'd5;
    localparam logic [OP_W-1:0] OP_COLD_RST  = 4'd6;
    localparam logic [OP_W-1:0] OP_REBOOT    = 4'd7;
    localparam logic [OP_W-1:0] OP_WARM_RST  = 4'd8;

    // Reported state codes.
    localparam logic [CODE_W-1:0] CODE_OFF    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ON     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_PGWAIT = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SETUP  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_BOOT   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_WORK   = 3'd5;
    localparam logic [CODE_W-1:0] CODE_SWOFF  = 3'd6;

    typedef enum logic [6:0] {
        ST_OFF    = 7'b0000001,
        ST_ON     = 7'b0000010,
        ST_PGWAIT = 7'b0000100,
        ST_SETUP  = 7'b0001000,
        ST_BOOT   = 7'b0010000,
        ST_WORK   = 7'b0100000,
        ST_SWOFF  = 7'b1000000
    } state_t;

    // One result transaction.
    typedef struct packed {
        logic [CODE_W-1:0] state_code;
        logic              converters_on;
        logic              fpga_reset_pulse;
        logic              clock_setup_start;
        logic              clear_fault_bits;
        logic              quiesce_event_send;
        logic              quiesce_mask_clear;
    } result_t;

    function automatic logic [CODE_W-1:0] state_code(input state_t st);
        logic [CODE_W-1:0] code;
        case (st)
            ST_OFF:    code = CODE_OFF;
            ST_ON:     code = CODE_ON;
            ST_PGWAIT: code = CODE_PGWAIT;
            ST_SETUP:  code = CODE_SETUP;
            ST_BOOT:   code = CODE_BOOT;
            ST_WORK:   code = CODE_WORK;
            ST_SWOFF:  code = CODE_SWOFF;
            default:   code = CODE_SWOFF;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* src/payload_power_sequencer_top.sv */
// Top level of the payload power sequencer: state machine and result register.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+-------------------------------------------
//  s_      | in        | s_valid / s_ready | op, fpga_done, core_power_good, event_ack
//  m_      | out       | m_valid / m_ready | state_code, converters_on and five pulses
//
// Each input transaction yields one result transaction, registered in the cycle after it is accepted.
// The next-state decision is a single level of logic on the state flags, so one
// transaction is taken every cycle unless m_ready holds a pending result; the result register is the only buffering.
// s_ready is high whenever the result register is empty or is being drained.
// Reset clears the sequencer to no power with all flags low and no result pending.
`default_nettype none

module payload_power_sequencer_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [3:0] s_op,
    input  wire logic       s_fpga_done,
    input  wire logic       s_core_power_good,
    input  wire logic       s_event_ack,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_state_code,
    output logic            m_converters_on,
    output logic            m_fpga_reset_pulse,
    output logic            m_clock_setup_start,
    output logic            m_clear_fault_bits,
    output logic            m_quiesce_event_send,
    output logic            m_quiesce_mask_clear
);

    ppseq_pkg::state_t  state_reg, state_next;
    logic               main_ok_reg, main_ok_next;
    logic               quiesce_reg, quiesce_next;
    logic               conv_reg, conv_next;
    logic               m_valid_reg, m_valid_next;
    ppseq_pkg::result_t result_reg, result_next;
    logic               s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        main_ok_next = main_ok_reg;
        quiesce_next = quiesce_reg;
        conv_next    = conv_reg;
        result_next  = '0;

        case (s_op)
            ppseq_pkg::OP_TICK: begin
                case (state_reg)
                    ppseq_pkg::ST_OFF: begin
                        if (main_ok_reg) begin
                            state_next = ppseq_pkg::ST_ON;
                        end
                        quiesce_next = 1'b0;
                    end
                    ppseq_pkg::ST_ON: begin
                        conv_next  = 1'b1;
                        state_next = ppseq_pkg::ST_PGWAIT;
                    end
                    ppseq_pkg::ST_PGWAIT: begin
                        result_next.clear_fault_bits = 1'b1;
                        if (quiesce_reg) begin
                            state_next = ppseq_pkg::ST_SWOFF;
                        end else if (s_core_power_good) begin
                            state_next = ppseq_pkg::ST_SETUP;
                        end
                    end
                    ppseq_pkg::ST_SETUP: begin
                        result_next.clock_setup_start = 1'b1;
                        state_next = ppseq_pkg::ST_BOOT;
                    end
                    ppseq_pkg::ST_BOOT: begin
                        if (quiesce_reg || !main_ok_reg) begin
                            state_next = ppseq_pkg::ST_SWOFF;
                        end else if (s_fpga_done) begin
                            state_next = ppseq_pkg::ST_WORK;
                        end
                    end
                    ppseq_pkg::ST_WORK: begin
                        if (quiesce_reg || !main_ok_reg) begin
                            state_next = ppseq_pkg::ST_SWOFF;
                        end
                    end
                    ppseq_pkg::ST_SWOFF: begin
                        conv_next = 1'b0;
                        result_next.quiesce_event_send = 1'b1;
                        if (s_event_ack) begin
                            quiesce_next = 1'b0;
                            main_ok_next = 1'b0;
                            result_next.quiesce_mask_clear = 1'b1;
                            state_next = ppseq_pkg::ST_OFF;
                        end
                    end
                    default: begin
                        state_next = ppseq_pkg::ST_SWOFF;
                    end
                endcase
            end
            ppseq_pkg::OP_P12_GOOD: main_ok_next = 1'b1;
            ppseq_pkg::OP_P12_LOST: main_ok_next = 1'b0;
            ppseq_pkg::OP_QUIESCE:  quiesce_next = 1'b1;
            ppseq_pkg::OP_COLD_RST: state_next   = ppseq_pkg::ST_SWOFF;
            ppseq_pkg::OP_REBOOT:   result_next.fpga_reset_pulse = 1'b1;
            // Core good or lost, warm reset and undefined opcodes change nothing.
            default: ;
        endcase

        result_next.state_code    = ppseq_pkg::state_code(state_next);
        result_next.converters_on = conv_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ppseq_pkg::ST_OFF;
            main_ok_reg <= 1'b0;
            quiesce_reg <= 1'b0;
            conv_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                state_reg   <= state_next;
                main_ok_reg <= main_ok_next;
                quiesce_reg <= quiesce_next;
                conv_reg    <= conv_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_state_code         = result_reg.state_code;
    assign m_converters_on      = result_reg.converters_on;
    assign m_fpga_reset_pulse   = result_reg.fpga_reset_pulse;
    assign m_clock_setup_start  = result_reg.clock_setup_start;
    assign m_clear_fault_bits   = result_reg.clear_fault_bits;
    assign m_quiesce_event_send = result_reg.quiesce_event_send;
    assign m_quiesce_mask_clear = result_reg.quiesce_mask_clear;

    // The converters are never enabled while the sequencer reports no power.
    a_off_conv_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_state_code == ppseq_pkg::CODE_OFF) |-> !m_converters_on)
        else $error("converters enabled in no power state");

    // Clearing the quiesced mask only happens on the tick that leaves switching off.
    a_mask_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_quiesce_mask_clear) |->
            (m_quiesce_event_send && m_state_code == ppseq_pkg::CODE_OFF))
        else $error("quiesce mask clear outside switching off exit");

    // A tick accepted in clock setup produces the setup request and enters booting.
    a_setup_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_op == ppseq_pkg::OP_TICK && state_reg == ppseq_pkg::ST_SETUP) |=>
            (m_valid && m_clock_setup_start && m_state_code == ppseq_pkg::CODE_BOOT))
        else $error("setup tick did not request clock setup");

endmodule

`default_nettype wire
